// ===== hw/rtl/fdtt_pkg.sv =====
// shared types, constants and helpers for the descriptor translation table
`timescale 1ns / 1ps

package fdtt_pkg;

  localparam int ENTRIES = 4;
  localparam int FD_BITS = 8;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PORT_W  = 8;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // one slot as seen through the read port
  typedef struct packed {
    logic               valid;
    logic [FD_BITS-1:0] slot_fd;
    logic [FD_BITS-1:0] host_fd;
    logic               dev_flag;
  } entry_t;

  // table update requests from the sequencer
  typedef struct packed {
    logic               clear_all;
    logic               inval_en;
    logic [IDX_W-1:0]   inval_idx;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    logic [FD_BITS-1:0] wr_slot_fd;
    logic [FD_BITS-1:0] wr_host_fd;
    logic               wr_dev_flag;
  } tbl_wr_t;

  // result of the shared compare unit
  typedef struct packed {
    logic               eq;
    logic               in_range;
    logic [ENTRIES-1:0] used_onehot;
  } cmp_res_t;

  // port word to internal descriptor width, zero extended or truncated
  function automatic logic [FD_BITS-1:0] to_fd(input logic [PORT_W-1:0] v);
    logic [FD_BITS+PORT_W-1:0] t;
    t = {{FD_BITS{1'b0}}, v};
    return t[FD_BITS-1:0];
  endfunction

  // internal descriptor to port word
  function automatic logic [PORT_W-1:0] from_fd(input logic [FD_BITS-1:0] f);
    logic [FD_BITS+PORT_W-1:0] t;
    t = {{PORT_W{1'b0}}, f};
    return t[PORT_W-1:0];
  endfunction

  localparam logic [FD_BITS-1:0] FD_ALL_ONES = {FD_BITS{1'b1}};
  localparam logic [PORT_W-1:0]  FULL_FD_OUT = from_fd(FD_ALL_ONES);

  // lowest index whose bit is clear
  function automatic logic [IDX_W-1:0] first_zero(input logic [ENTRIES-1:0] m);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!m[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/fdtt_cmp.sv =====
// shared compare unit: key match and allocation range check for one slot
`timescale 1ns / 1ps

module fdtt_cmp (
  input  logic [fdtt_pkg::FD_BITS-1:0] entry_fd,
  input  logic [fdtt_pkg::FD_BITS-1:0] key_fd,
  output fdtt_pkg::cmp_res_t           res
);

  logic in_range;

  assign in_range = {1'b0, entry_fd} < (fdtt_pkg::FD_BITS + 1)'(fdtt_pkg::ENTRIES);

  assign res.eq       = (entry_fd == key_fd);
  assign res.in_range = in_range;
  // marks which candidate descriptor this slot occupies
  assign res.used_onehot = in_range ?
      (fdtt_pkg::ENTRIES'(1) << entry_fd[fdtt_pkg::IDX_W-1:0]) : '0;

endmodule

// ===== hw/rtl/fdtt_table.sv =====
// slot storage: valid bits, local and host descriptors, device flags
`timescale 1ns / 1ps

module fdtt_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [fdtt_pkg::IDX_W-1:0]    rd_idx,
  input  fdtt_pkg::tbl_wr_t             upd,
  output fdtt_pkg::entry_t              rd_ent,
  output logic [fdtt_pkg::ENTRIES-1:0]  valid_vec
);

  logic [fdtt_pkg::ENTRIES-1:0] valid_r;
  logic [fdtt_pkg::FD_BITS-1:0] local_r [fdtt_pkg::ENTRIES];
  logic [fdtt_pkg::FD_BITS-1:0] host_r  [fdtt_pkg::ENTRIES];
  logic                         flag_r  [fdtt_pkg::ENTRIES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < fdtt_pkg::ENTRIES; i++) local_r[i] <= '0;
    end else begin
      if (upd.clear_all) begin
        valid_r <= '0;
      end else if (upd.inval_en) begin
        valid_r[upd.inval_idx] <= 1'b0;
      end else if (upd.wr_en) begin
        valid_r[upd.wr_idx] <= 1'b1;
        local_r[upd.wr_idx] <= upd.wr_slot_fd;
      end
    end
  end

  // host side carries no reset, only read once written
  always_ff @(posedge clk) begin
    if (upd.wr_en && !upd.clear_all && !upd.inval_en) begin
      host_r[upd.wr_idx] <= upd.wr_host_fd;
      flag_r[upd.wr_idx] <= upd.wr_dev_flag;
    end
  end

  assign valid_vec       = valid_r;
  assign rd_ent.valid    = valid_r[rd_idx];
  assign rd_ent.slot_fd  = local_r[rd_idx];
  assign rd_ent.host_fd  = host_r[rd_idx];
  assign rd_ent.dev_flag = flag_r[rd_idx];

endmodule

// ===== hw/rtl/file_descriptor_translation_table.sv =====
// top level: sequencer stepping the shared compare unit over the table slots
`timescale 1ns / 1ps

// Descriptor translation table. Raise start with a word on the in_ ports while
// busy is low; the word is taken at that edge. Clear all finishes in the
// accept cycle and its result strobes out_valid in the next cycle, with busy
// staying low, so one clear per cycle is possible. Lookup, insert and remove
// step one slot per cycle through a single compare unit, so they hold busy
// while they scan all ENTRIES slots and strobe the result as busy falls; a new
// word is taken only once busy is low again. out_valid is high for exactly one
// cycle and the result must be taken then; there is no way to stall it.
// Unused result fields read zero; a full table on insert returns all ones.

module file_descriptor_translation_table (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_op,
  input  logic [7:0] in_fd_value,
  input  logic       in_device_flag_in,
  output logic       out_valid,
  output logic [7:0] out_new_local_fd,
  output logic [7:0] out_translated_fd,
  output logic       out_device_flag_out,
  output logic       out_table_full
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  localparam logic [fdtt_pkg::IDX_W-1:0] LAST_IDX =
      fdtt_pkg::IDX_W'(fdtt_pkg::ENTRIES - 1);

  state_t                        state_r;
  fdtt_pkg::op_t                 op_r;
  logic [fdtt_pkg::FD_BITS-1:0]  key_r;
  logic                          flag_in_r;
  logic [fdtt_pkg::IDX_W-1:0]    idx_r;
  logic [fdtt_pkg::FD_BITS-1:0]  trans_r;
  logic                          dflag_r;
  logic [fdtt_pkg::ENTRIES-1:0]  used_r;

  logic                          out_valid_r;
  logic [7:0]                    new_fd_r;
  logic [7:0]                    trans_out_r;
  logic                          dflag_out_r;
  logic                          full_r;

  fdtt_pkg::entry_t              ent;
  fdtt_pkg::cmp_res_t            cmp;
  fdtt_pkg::tbl_wr_t             upd;
  logic [fdtt_pkg::ENTRIES-1:0]  valid_vec;

  logic                          accept;
  logic                          scan_last;
  logic                          hit;
  logic [fdtt_pkg::ENTRIES-1:0]  used_nxt;
  logic [fdtt_pkg::FD_BITS-1:0]  trans_nxt;
  logic                          dflag_nxt;
  logic                          tbl_full;
  logic [fdtt_pkg::IDX_W-1:0]    free_slot;
  logic [fdtt_pkg::IDX_W-1:0]    pick_idx;

  fdtt_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_idx    (idx_r),
    .upd       (upd),
    .rd_ent    (ent),
    .valid_vec (valid_vec)
  );

  fdtt_cmp u_cmp (
    .entry_fd (ent.slot_fd),
    .key_fd   (key_r),
    .res      (cmp)
  );

  assign busy      = (state_r == ST_SCAN);
  assign accept    = start && !busy;
  assign scan_last = (state_r == ST_SCAN) && (idx_r == LAST_IDX);
  assign hit       = ent.valid && cmp.eq;

  // running state including the slot under the compare unit this cycle
  assign used_nxt  = used_r | (ent.valid ? cmp.used_onehot : '0);
  assign trans_nxt = hit ? ent.host_fd : trans_r;
  assign dflag_nxt = hit ? ent.dev_flag : dflag_r;

  assign tbl_full  = &valid_vec;
  assign free_slot = fdtt_pkg::first_zero(valid_vec);
  assign pick_idx  = fdtt_pkg::first_zero(used_nxt);

  always_comb begin
    upd             = '0;
    upd.clear_all   = accept && (fdtt_pkg::op_t'(in_op) == fdtt_pkg::OP_CLEAR);
    upd.inval_en    = (state_r == ST_SCAN) && (op_r == fdtt_pkg::OP_REMOVE) && cmp.eq;
    upd.inval_idx   = idx_r;
    upd.wr_en       = scan_last && (op_r == fdtt_pkg::OP_INSERT) && !tbl_full;
    upd.wr_idx      = free_slot;
    upd.wr_slot_fd  = fdtt_pkg::FD_BITS'(pick_idx);
    upd.wr_host_fd  = key_r;
    upd.wr_dev_flag = flag_in_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            op_r      <= fdtt_pkg::op_t'(in_op);
            key_r     <= fdtt_pkg::to_fd(in_fd_value);
            flag_in_r <= in_device_flag_in;
            idx_r     <= '0;
            trans_r   <= fdtt_pkg::to_fd(in_fd_value);
            dflag_r   <= 1'b0;
            used_r    <= '0;
            if (fdtt_pkg::op_t'(in_op) == fdtt_pkg::OP_CLEAR) begin
              out_valid_r <= 1'b1;
              new_fd_r    <= '0;
              trans_out_r <= '0;
              dflag_out_r <= 1'b0;
              full_r      <= 1'b0;
            end else begin
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          used_r  <= used_nxt;
          trans_r <= trans_nxt;
          dflag_r <= dflag_nxt;
          idx_r   <= idx_r + 1'b1;
          if (scan_last) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
            new_fd_r    <= '0;
            trans_out_r <= '0;
            dflag_out_r <= 1'b0;
            full_r      <= 1'b0;
            unique case (op_r)
              fdtt_pkg::OP_LOOKUP: begin
                trans_out_r <= fdtt_pkg::from_fd(trans_nxt);
                dflag_out_r <= dflag_nxt;
              end
              fdtt_pkg::OP_INSERT: begin
                if (tbl_full) begin
                  new_fd_r <= fdtt_pkg::FULL_FD_OUT;
                  full_r   <= 1'b1;
                end else begin
                  new_fd_r <= fdtt_pkg::from_fd(fdtt_pkg::FD_BITS'(pick_idx));
                end
              end
              fdtt_pkg::OP_REMOVE,
              fdtt_pkg::OP_CLEAR: begin
                new_fd_r <= '0;
              end
            endcase
          end
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_new_local_fd    = new_fd_r;
  assign out_translated_fd   = trans_out_r;
  assign out_device_flag_out = dflag_out_r;
  assign out_table_full      = full_r;

endmodule

// ===== hw/rtl/fdtt_checker.sv =====
// port-level checks for the descriptor translation table, bound to the top level
`timescale 1ns / 1ps

module fdtt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_op,
  input logic       out_valid,
  input logic [7:0] out_new_local_fd,
  input logic [7:0] out_translated_fd,
  input logic       out_device_flag_out,
  input logic       out_table_full
);

  // clear completes at once and strobes a word next cycle
  a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
      (rst_n && start && !busy && in_op == fdtt_pkg::OP_CLEAR) |=> out_valid)
    else $error("clear did not return a word in the next cycle");

  // any other op occupies the scan
  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
      (rst_n && start && !busy && in_op != fdtt_pkg::OP_CLEAR) |=> (busy && !out_valid))
    else $error("scan op did not raise busy");

  // result only appears once the sequencer is idle again
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> !busy)
    else $error("result strobed while busy");

  // full flag comes with the all-ones descriptor and nothing else
  a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid && out_table_full) |->
        (out_new_local_fd == fdtt_pkg::FULL_FD_OUT && out_translated_fd == 8'd0
         && !out_device_flag_out))
    else $error("table full word malformed");

endmodule

bind file_descriptor_translation_table fdtt_checker u_fdtt_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .in_op               (in_op),
  .out_valid           (out_valid),
  .out_new_local_fd    (out_new_local_fd),
  .out_translated_fd   (out_translated_fd),
  .out_device_flag_out (out_device_flag_out),
  .out_table_full      (out_table_full)
);

// ===== sim/file_descriptor_translation_table_tb.sv =====
// testbench for the descriptor translation table: random and directed table ops
`timescale 1ns / 1ps

module file_descriptor_translation_table_tb;

  localparam int N_RANDOM     = 1250;
  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    fdtt_pkg::op_t op;
    logic [7:0]    fd;
    logic          flag;
    int            gap;
    bit            drain;
  } fd_req_t;

  typedef struct packed {
    logic [7:0] new_fd;
    logic [7:0] trans_fd;
    logic       dev;
    logic       full;
  } fd_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] in_op = fdtt_pkg::OP_LOOKUP;
  logic [7:0] in_fd_value = 8'd0;
  logic       in_device_flag_in = 1'b0;
  logic       out_valid;
  logic [7:0] out_new_local_fd;
  logic [7:0] out_translated_fd;
  logic       out_device_flag_out;
  logic       out_table_full;

  fd_req_t    fd_requests[$];
  fd_result_t fd_results[$];
  int         err_cnt = 0;
  int         gap_left = 0;
  int         cycle_cnt = 0;

  // shadow copy of the table
  logic                         tbl_valid [fdtt_pkg::ENTRIES];
  logic [fdtt_pkg::FD_BITS-1:0] tbl_local [fdtt_pkg::ENTRIES];
  logic [fdtt_pkg::FD_BITS-1:0] tbl_host  [fdtt_pkg::ENTRIES];
  logic                         tbl_dev   [fdtt_pkg::ENTRIES];

  file_descriptor_translation_table u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_op               (in_op),
    .in_fd_value         (in_fd_value),
    .in_device_flag_in   (in_device_flag_in),
    .out_valid           (out_valid),
    .out_new_local_fd    (out_new_local_fd),
    .out_translated_fd   (out_translated_fd),
    .out_device_flag_out (out_device_flag_out),
    .out_table_full      (out_table_full)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // applies one op to the shadow table and returns the result it yields
  function automatic fd_result_t apply_fd_op(fd_req_t q);
    fd_result_t                   r;
    int                           slot;
    logic [fdtt_pkg::FD_BITS-1:0] pick;
    logic                         used;
    r = '0;
    case (q.op)
      fdtt_pkg::OP_LOOKUP: begin
        r.trans_fd = q.fd;
        // later slots override earlier ones
        for (int k = 0; k < fdtt_pkg::ENTRIES; k++) begin
          if (tbl_valid[k] && tbl_local[k] == q.fd) begin
            r.trans_fd = tbl_host[k];
            r.dev      = tbl_dev[k];
          end
        end
      end
      fdtt_pkg::OP_INSERT: begin
        slot = -1;
        for (int k = 0; k < fdtt_pkg::ENTRIES; k++) begin
          if (slot < 0 && !tbl_valid[k]) slot = k;
        end
        if (slot < 0) begin
          r.new_fd = 8'hFF;
          r.full   = 1'b1;
        end else begin
          pick = '1;
          for (int c = fdtt_pkg::ENTRIES - 1; c >= 0; c--) begin
            used = 1'b0;
            for (int k = 0; k < fdtt_pkg::ENTRIES; k++) begin
              if (tbl_valid[k] && tbl_local[k] == fdtt_pkg::FD_BITS'(c)) used = 1'b1;
            end
            if (!used) pick = fdtt_pkg::FD_BITS'(c);
          end
          tbl_valid[slot] = 1'b1;
          tbl_local[slot] = pick;
          tbl_host[slot]  = q.fd;
          tbl_dev[slot]   = q.flag;
          r.new_fd        = pick;
        end
      end
      fdtt_pkg::OP_REMOVE: begin
        // stale slots with the same descriptor are hit too
        for (int k = 0; k < fdtt_pkg::ENTRIES; k++) begin
          if (tbl_local[k] == q.fd) tbl_valid[k] = 1'b0;
        end
      end
      default: begin
        for (int k = 0; k < fdtt_pkg::ENTRIES; k++) tbl_valid[k] = 1'b0;
      end
    endcase
    return r;
  endfunction

  task automatic add_req(fdtt_pkg::op_t op, int fd, int flag, int gap, bit drain);
    fd_req_t q;
    q.op    = op;
    q.fd    = 8'(fd);
    q.flag  = 1'(flag);
    q.gap   = gap;
    q.drain = drain;
    fd_requests.push_back(q);
  endtask

  // driver: presents the oldest pending word and holds it until taken
  always @(posedge clk) begin : drive
    bit launch;
    launch = 1'b0;
    if (rst_n) begin
      if (start && !busy) begin
        fd_results.push_back(apply_fd_op(fd_requests.pop_front()));
        if (fd_requests.size() != 0) begin
          gap_left = fd_requests[0].gap;
          launch   = (gap_left == 0) && !fd_requests[0].drain;
        end
      end else if (!start && fd_requests.size() != 0) begin
        if (gap_left > 0) gap_left--;
        else if (!fd_requests[0].drain || fd_results.size() == 0) launch = 1'b1;
      end
      if (launch) begin
        in_op             <= fd_requests[0].op;
        in_fd_value       <= fd_requests[0].fd;
        in_device_flag_in <= fd_requests[0].flag;
        start             <= 1'b1;
      end else if (start && !busy) begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every strobed word is checked against the oldest expectation
  always @(posedge clk) begin : check
    fd_result_t want;
    if (rst_n && out_valid) begin
      if (fd_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("unexpected result word: new_fd=%0d trans_fd=%0d dev=%0b full=%0b",
                   out_new_local_fd, out_translated_fd, out_device_flag_out,
                   out_table_full);
      end else begin
        want = fd_results.pop_front();
        if (out_new_local_fd !== want.new_fd || out_translated_fd !== want.trans_fd ||
            out_device_flag_out !== want.dev || out_table_full !== want.full) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display({"mismatch: exp new_fd=%0d trans_fd=%0d dev=%0b full=%0b,",
                      " got new_fd=%0d trans_fd=%0d dev=%0b full=%0b"},
                     want.new_fd, want.trans_fd, want.dev, want.full,
                     out_new_local_fd, out_translated_fd, out_device_flag_out,
                     out_table_full);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int            r;
    int            fd;
    int            gap;
    fdtt_pkg::op_t op;
    for (int k = 0; k < fdtt_pkg::ENTRIES; k++) begin
      tbl_valid[k] = 1'b0;
      tbl_local[k] = '0;
      tbl_host[k]  = '0;
      tbl_dev[k]   = 1'b0;
    end

    // empty table passes descriptors through
    add_req(fdtt_pkg::OP_LOOKUP, 0, 1, 0, 0);
    add_req(fdtt_pkg::OP_LOOKUP, 255, 0, 0, 0);
    // fill the table, then one insert too many
    add_req(fdtt_pkg::OP_INSERT, 0, 0, 0, 0);
    add_req(fdtt_pkg::OP_INSERT, 255, 1, 2, 0);
    add_req(fdtt_pkg::OP_INSERT, 8'hAA, 1, 0, 0);
    add_req(fdtt_pkg::OP_INSERT, 8'h55, 0, 7, 0);
    add_req(fdtt_pkg::OP_INSERT, 8'h12, 1, 0, 0);
    add_req(fdtt_pkg::OP_LOOKUP, 0, 0, 0, 1);
    add_req(fdtt_pkg::OP_LOOKUP, 1, 0, 0, 0);
    add_req(fdtt_pkg::OP_LOOKUP, 2, 0, 3, 0);
    add_req(fdtt_pkg::OP_LOOKUP, 3, 1, 0, 0);
    add_req(fdtt_pkg::OP_LOOKUP, 4, 1, 0, 0);
    // free slots out of order, then insert again into the freed slots
    add_req(fdtt_pkg::OP_REMOVE, 2, 0, 0, 0);
    add_req(fdtt_pkg::OP_REMOVE, 0, 1, 1, 0);
    add_req(fdtt_pkg::OP_REMOVE, 200, 0, 0, 0);
    add_req(fdtt_pkg::OP_INSERT, 8'h77, 1, 0, 0);
    add_req(fdtt_pkg::OP_INSERT, 8'h88, 0, 0, 0);
    add_req(fdtt_pkg::OP_LOOKUP, 0, 0, 0, 0);
    add_req(fdtt_pkg::OP_LOOKUP, 2, 0, 0, 0);
    add_req(fdtt_pkg::OP_REMOVE, 255, 1, 0, 0);
    // back to back clears, then stale descriptors must not match
    add_req(fdtt_pkg::OP_CLEAR, 0, 0, 0, 0);
    add_req(fdtt_pkg::OP_CLEAR, 255, 1, 0, 0);
    add_req(fdtt_pkg::OP_LOOKUP, 1, 0, 0, 0);
    add_req(fdtt_pkg::OP_INSERT, 8'h3C, 1, 0, 0);
    add_req(fdtt_pkg::OP_LOOKUP, 0, 0, 0, 0);

    for (int i = 0; i < N_RANDOM; i++) begin
      r = $urandom_range(99);
      if (r < 35)      op = fdtt_pkg::OP_INSERT;
      else if (r < 72) op = fdtt_pkg::OP_LOOKUP;
      else if (r < 95) op = fdtt_pkg::OP_REMOVE;
      else             op = fdtt_pkg::OP_CLEAR;
      if (op != fdtt_pkg::OP_INSERT && $urandom_range(4) != 0)
        fd = $urandom_range(fdtt_pkg::ENTRIES);
      else
        fd = $urandom_range(255);
      r = $urandom_range(99);
      if ((i / 100) % 3 == 0) gap = 0;
      else if (r < 55)        gap = 0;
      else if (r < 90)        gap = $urandom_range(1, 6);
      else                    gap = $urandom_range(15, 60);
      add_req(op, fd, $urandom_range(1), gap,
              (i == N_RANDOM / 2) || ($urandom_range(199) == 0));
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (fd_requests.size() != 0 || start) @(posedge clk);
    while (fd_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0 && fd_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
